// File: design/sha1_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and round functions of the SHA-1 digest block.
// Depends on nothing; used by sha1_message_digest and its testbench.
package sha1_pkg;

   typedef logic [31:0] word_type;
   typedef word_type    chain_type [5];

   localparam int BLOCK_BYTES  = 64;
   localparam int BLOCK_BITS   = 8 * BLOCK_BYTES;
   localparam int DIGEST_WORDS = 5;
   localparam int ROUNDS       = 80;
   localparam int LENGTH_BITS  = 61;

   // Byte offset inside a block at which the 64-bit length field starts.
   localparam logic [5:0] LENGTH_OFFSET = 6'd56;
   localparam logic [5:0] LAST_BYTE     = 6'(BLOCK_BYTES - 1);
   localparam logic [6:0] LAST_ROUND    = 7'(ROUNDS - 1);
   localparam logic [2:0] LAST_WORD     = 3'(DIGEST_WORDS - 1);
   localparam logic [7:0] PAD_MARK      = 8'h80;

   localparam chain_type CHAIN_INIT = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam word_type K_ROUND0 = 32'h5A827999;
   localparam word_type K_ROUND1 = 32'h6ED9EBA1;
   localparam word_type K_ROUND2 = 32'h8F1BBCDC;
   localparam word_type K_ROUND3 = 32'hCA62C1D6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD_MARK,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_COMPRESS,
      ST_FOLD,
      ST_OUTPUT
   } state_type;

   // Boolean function of the round, chosen by the round group.
   function automatic word_type round_f(logic [6:0] r, word_type b, word_type c,
                                        word_type d);
      word_type f;
      if (r < 7'd20) begin
         f = (b & c) | (~b & d);
      end else if (r < 7'd40) begin
         f = b ^ c ^ d;
      end else if (r < 7'd60) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

   function automatic word_type round_k(logic [6:0] r);
      word_type k;
      if (r < 7'd20) begin
         k = K_ROUND0;
      end else if (r < 7'd40) begin
         k = K_ROUND1;
      end else if (r < 7'd60) begin
         k = K_ROUND2;
      end else begin
         k = K_ROUND3;
      end
      return k;
   endfunction

endpackage

// File: design/sha1_message_digest.sv
`timescale 1ns / 1ps
// SHA-1 message digest over a byte stream, with one shared round unit.
// Depends on sha1_pkg for types, constants and the round functions.
//
// The req channel carries one message byte per transaction in req_tdata, with
// req_tuser set when the byte is present and req_tlast on the final transaction
// of a message. An empty message is one final transaction without a byte, and a
// non-final transaction without a byte is taken and ignored. The rsp channel
// returns the 160-bit digest as five transactions, word 0 first, with the word
// position in rsp_tuser and rsp_tlast on the fifth word.
// Bytes shift into a 512-bit block register, one per accepted transaction that
// carries a byte. Every full block runs 80 rounds through a single round adder,
// one round per cycle, then a fold step adds the result into the chain words;
// req_tready is low during the rounds and the fold.
// After the final transaction the sequencer writes the padding one byte per
// cycle, pausing while a full block is compressed, and compresses one or two
// more blocks before the first digest word shows. The block takes no new
// transaction until the fifth digest word has been accepted; while the
// receiver stalls rsp_tvalid and the word simply hold.
// Reset clears the sequencer, the byte and length counters and loads the
// initial chain value; the block and round registers need no reset.
module sha1_message_digest (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] byte_present
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast    // last_word
);

   sha1_pkg::state_type state_ff, state_in;
   sha1_pkg::state_type ret_ff, ret_in;
   logic [5:0]          fill_ff, fill_in;
   logic [sha1_pkg::LENGTH_BITS-1:0] len_ff, len_in;
   logic [sha1_pkg::BLOCK_BITS-1:0]  blk_ff, blk_in;
   sha1_pkg::chain_type chain_ff, chain_in;
   sha1_pkg::chain_type rnd_ff, rnd_in;
   logic [6:0]          round_ff, round_in;
   logic [2:0]          word_idx_ff, word_idx_in;

   logic                push;
   logic [7:0]          push_data;
   logic                block_full;
   logic [63:0]         len_bits;
   sha1_pkg::state_type after_push;

   // Window words of the block register; word 0 sits in the top bits.
   sha1_pkg::word_type  w0, w2, w8, w13, w_next, sum;

   assign len_bits = {len_ff, 3'b000};
   assign w0  = blk_ff[sha1_pkg::BLOCK_BITS-1      -: 32];
   assign w2  = blk_ff[sha1_pkg::BLOCK_BITS-1-64   -: 32];
   assign w8  = blk_ff[sha1_pkg::BLOCK_BITS-1-256  -: 32];
   assign w13 = blk_ff[sha1_pkg::BLOCK_BITS-1-416  -: 32];

   // Next schedule word, rotated left by one.
   always_comb begin
      sha1_pkg::word_type x;
      x = w13 ^ w8 ^ w2 ^ w0;
      w_next = {x[30:0], x[31]};
   end

   // The shared round adder.
   assign sum = {rnd_ff[0][26:0], rnd_ff[0][31:27]}
              + sha1_pkg::round_f(round_ff, rnd_ff[1], rnd_ff[2], rnd_ff[3])
              + rnd_ff[4] + sha1_pkg::round_k(round_ff) + w0;

   // Sequencer outputs: handshakes and the byte pushed into the block.
   always_comb begin
      req_tready = (state_ff == sha1_pkg::ST_IDLE);
      rsp_tvalid = (state_ff == sha1_pkg::ST_OUTPUT);
      push       = 1'b0;
      push_data  = '0;
      after_push = state_ff;
      unique case (state_ff)
         sha1_pkg::ST_IDLE: begin
            push       = req_tvalid & req_tuser;
            push_data  = req_tdata;
            after_push = req_tlast ? sha1_pkg::ST_PAD_MARK : sha1_pkg::ST_IDLE;
         end
         sha1_pkg::ST_PAD_MARK: begin
            push       = 1'b1;
            push_data  = sha1_pkg::PAD_MARK;
            after_push = sha1_pkg::ST_PAD_ZERO;
         end
         sha1_pkg::ST_PAD_ZERO: begin
            push       = (fill_ff != sha1_pkg::LENGTH_OFFSET);
            after_push = sha1_pkg::ST_PAD_ZERO;
         end
         sha1_pkg::ST_PAD_LEN: begin
            // Length bytes go out most significant first.
            push       = 1'b1;
            push_data  = len_bits[{~fill_ff[2:0], 3'b000} +: 8];
            after_push = sha1_pkg::ST_OUTPUT;
         end
         default: begin
         end
      endcase
      block_full = push && (fill_ff == sha1_pkg::LAST_BYTE);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      unique case (state_ff)
         sha1_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (block_full) begin
                  state_in = sha1_pkg::ST_COMPRESS;
                  ret_in   = after_push;
               end else begin
                  state_in = after_push;
               end
            end
         end
         sha1_pkg::ST_PAD_MARK: begin
            if (block_full) begin
               state_in = sha1_pkg::ST_COMPRESS;
               ret_in   = after_push;
            end else begin
               state_in = after_push;
            end
         end
         sha1_pkg::ST_PAD_ZERO: begin
            if (!push) begin
               state_in = sha1_pkg::ST_PAD_LEN;
            end else if (block_full) begin
               state_in = sha1_pkg::ST_COMPRESS;
               ret_in   = after_push;
            end
         end
         sha1_pkg::ST_PAD_LEN: begin
            if (block_full) begin
               state_in = sha1_pkg::ST_COMPRESS;
               ret_in   = after_push;
            end
         end
         sha1_pkg::ST_COMPRESS: begin
            if (round_ff == sha1_pkg::LAST_ROUND) begin
               state_in = sha1_pkg::ST_FOLD;
            end
         end
         sha1_pkg::ST_FOLD: begin
            state_in = ret_ff;
         end
         sha1_pkg::ST_OUTPUT: begin
            if (rsp_tready && (word_idx_ff == sha1_pkg::LAST_WORD)) begin
               state_in = sha1_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sha1_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      fill_in     = fill_ff;
      len_in      = len_ff;
      blk_in      = blk_ff;
      chain_in    = chain_ff;
      rnd_in      = rnd_ff;
      round_in    = round_ff;
      word_idx_in = word_idx_ff;

      if (push) begin
         blk_in  = {blk_ff[sha1_pkg::BLOCK_BITS-9:0], push_data};
         fill_in = fill_ff + 6'd1;
      end
      if ((state_ff == sha1_pkg::ST_IDLE) && req_tvalid && req_tuser) begin
         len_in = len_ff + 1'b1;
      end
      if (block_full) begin
         rnd_in   = chain_ff;
         round_in = '0;
      end

      if (state_ff == sha1_pkg::ST_COMPRESS) begin
         blk_in    = {blk_ff[sha1_pkg::BLOCK_BITS-33:0], w_next};
         rnd_in[0] = sum;
         rnd_in[1] = rnd_ff[0];
         rnd_in[2] = {rnd_ff[1][1:0], rnd_ff[1][31:2]};
         rnd_in[3] = rnd_ff[2];
         rnd_in[4] = rnd_ff[3];
         round_in  = round_ff + 7'd1;
      end

      if (state_ff == sha1_pkg::ST_FOLD) begin
         for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
            chain_in[i] = chain_ff[i] + rnd_ff[i];
         end
      end

      if ((state_ff == sha1_pkg::ST_OUTPUT) && rsp_tready) begin
         if (word_idx_ff == sha1_pkg::LAST_WORD) begin
            word_idx_in = '0;
            chain_in    = sha1_pkg::CHAIN_INIT;
            len_in      = '0;
         end else begin
            word_idx_in = word_idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= sha1_pkg::ST_IDLE;
         ret_ff      <= sha1_pkg::ST_IDLE;
         fill_ff     <= '0;
         len_ff      <= '0;
         chain_ff    <= sha1_pkg::CHAIN_INIT;
         round_ff    <= '0;
         word_idx_ff <= '0;
      end else begin
         state_ff    <= state_in;
         ret_ff      <= ret_in;
         fill_ff     <= fill_in;
         len_ff      <= len_in;
         chain_ff    <= chain_in;
         round_ff    <= round_in;
         word_idx_ff <= word_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      rnd_ff <= rnd_in;
   end

   assign rsp_tdata = chain_ff[word_idx_ff];
   assign rsp_tuser = word_idx_ff;
   assign rsp_tlast = (word_idx_ff == sha1_pkg::LAST_WORD);

   // The digest is only shown once the padded message has been fully consumed.
   a_output_block_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sha1_pkg::ST_OUTPUT) |-> (fill_ff == '0) && (len_ff != len_ff + 1'b1))
      else $error("digest shown with bytes left in the block");

   // The round counter never runs past the last round.
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sha1_pkg::ST_COMPRESS) |-> (round_ff <= sha1_pkg::LAST_ROUND))
      else $error("round counter out of range");

   // After the last digest word the chain is back at its initial value.
   a_chain_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=>
         (chain_ff[0] == sha1_pkg::CHAIN_INIT[0]) && (len_ff == '0) && req_tready)
      else $error("chain not restarted after digest");

   // Input and output sides are never open in the same cycle.
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input accepted while digest pending");

endmodule

// File: verif/tb_sha1_message_digest.sv
`timescale 1ns / 1ps
// Self-checking testbench for the byte-stream SHA-1 digest block.
// Depends on sha1_pkg for the word type, the chain start value and the round constants.
module tb_sha1_message_digest;

   // One transaction on the request channel, with the pacing that goes with it.
   typedef struct {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
      int         gap;        // idle cycles before this transaction is offered
      bit         drain;      // hold this transaction until every digest word is back
      bit         calm;       // no stalls on either side while this message runs
   } msg_item_type;

   // One digest word as the block is expected to return it.
   typedef struct {
      sha1_pkg::word_type digest_word;
      logic [2:0]         word_index;
      logic               last_word;
   } digest_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic        req_tuser = 1'b0;    // [0] byte_present
   logic        req_tlast = 1'b0;    // end_of_message
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;           // [31:0] digest_word
   logic [2:0]  rsp_tuser;           // [2:0] word_index
   logic        rsp_tlast;           // last_word

   sha1_message_digest u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   msg_item_type    pending_items[$];
   digest_beat_type digest_words_due[$];
   int              mismatch_count = 0;

   // Handshake flags and pacing state of the rising-edge monitor and the
   // falling-edge drivers. They are only touched at clock edges, the monitor's
   // at one and the drivers' at the other, so there is no race inside a time step.
   bit req_fired = 1'b0;
   int req_gap_done = 0;
   bit rsp_calm = 1'b0;
   int rsp_stall = 0;

   // ---------------------------------------------------------------------
   // Digest predictor: its own copy of the chain words, the block buffer,
   // the fill level and the message byte count.
   // ---------------------------------------------------------------------
   sha1_pkg::chain_type hash_chain = sha1_pkg::CHAIN_INIT;
   logic [7:0]          block_bytes [64];
   logic [5:0]          block_fill = '0;
   logic [60:0]         byte_count = '0;

   // Runs the 80 SHA-1 rounds over the buffered block and folds the result
   // into the chain words. The schedule is kept as a rolling 16-word window.
   task automatic run_compression();
      sha1_pkg::word_type sched [16];
      sha1_pkg::word_type a, b, c, d, e, f, k, sum;
      for (int t = 0; t < 16; t++) begin
         sched[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2],
                     block_bytes[4*t+3]};
      end
      a = hash_chain[0];
      b = hash_chain[1];
      c = hash_chain[2];
      d = hash_chain[3];
      e = hash_chain[4];
      for (int r = 0; r < sha1_pkg::ROUNDS; r++) begin
         if (r >= 16) begin
            sum = sched[(r+13)%16] ^ sched[(r+8)%16] ^ sched[(r+2)%16] ^ sched[r%16];
            sched[r%16] = {sum[30:0], sum[31]};
         end
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = sha1_pkg::K_ROUND0;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = sha1_pkg::K_ROUND1;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = sha1_pkg::K_ROUND2;
         end else begin
            f = b ^ c ^ d;
            k = sha1_pkg::K_ROUND3;
         end
         sum = {a[26:0], a[31:27]} + f + e + k + sched[r%16];
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = sum;
      end
      hash_chain[0] += a;
      hash_chain[1] += b;
      hash_chain[2] += c;
      hash_chain[3] += d;
      hash_chain[4] += e;
   endtask

   task automatic absorb_byte(input logic [7:0] value);
      block_bytes[block_fill] = value;
      if (block_fill == sha1_pkg::LAST_BYTE) begin
         run_compression();
      end
      block_fill = block_fill + 6'd1;
   endtask

   // Applies one accepted request transaction. A final transaction pads the
   // message, queues the five digest words and restarts the chain.
   task automatic predict_digest(input logic [7:0] data, input logic present,
                                 input logic final_item);
      logic [63:0] bit_length;
      digest_beat_type beat;
      if (present) begin
         absorb_byte(data);
         byte_count = byte_count + 61'd1;
      end
      if (final_item) begin
         bit_length = {byte_count, 3'b000};
         absorb_byte(sha1_pkg::PAD_MARK);
         while (block_fill != sha1_pkg::LENGTH_OFFSET) begin
            absorb_byte(8'h00);
         end
         for (int i = 7; i >= 0; i--) begin
            absorb_byte(bit_length[8*i +: 8]);
         end
         for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
            beat.digest_word = hash_chain[i];
            beat.word_index  = 3'(i);
            beat.last_word   = (3'(i) == sha1_pkg::LAST_WORD);
            digest_words_due.push_back(beat);
         end
         hash_chain = sha1_pkg::CHAIN_INIT;
         block_fill = '0;
         byte_count = '0;
      end
   endtask

   // ---------------------------------------------------------------------
   // Monitor: samples both channels at the rising edge. An accepted request
   // updates the predictor; an accepted digest word is checked against the
   // oldest expected word, field by field.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         req_fired = 1'b1;
         predict_digest(req_tdata, req_tuser, req_tlast);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_stall = rsp_calm ? 0 : $urandom_range(0, 11);
         if (digest_words_due.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected digest transaction: expected none, actual word=%h "
                     , $time, rsp_tdata, "index=%0d last=%0b", rsp_tuser, rsp_tlast);
         end else begin
            if (rsp_tdata !== digest_words_due[0].digest_word) begin
               mismatch_count++;
               $display("%0t: digest_word mismatch: expected %h, actual %h", $time,
                        digest_words_due[0].digest_word, rsp_tdata);
            end
            if (rsp_tuser !== digest_words_due[0].word_index) begin
               mismatch_count++;
               $display("%0t: word_index mismatch: expected %0d, actual %0d", $time,
                        digest_words_due[0].word_index, rsp_tuser);
            end
            if (rsp_tlast !== digest_words_due[0].last_word) begin
               mismatch_count++;
               $display("%0t: last_word mismatch: expected %0b, actual %0b", $time,
                        digest_words_due[0].last_word, rsp_tlast);
            end
            void'(digest_words_due.pop_front());
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request driver: changes inputs at the falling edge. A transaction on
   // offer is held until it is taken. Each transaction carries its own idle
   // gap, and a drain mark makes the sender wait until all digest words of
   // earlier messages have come back. Every branch but the wait assigns req_tvalid once.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_fired) begin
         // Waiting for the block to take the transaction on offer.
      end else begin
         req_fired = 1'b0;
         if (pending_items.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (pending_items[0].drain && digest_words_due.size() != 0) begin
            req_tvalid <= 1'b0;
         end else if (req_gap_done < pending_items[0].gap) begin
            req_tvalid <= 1'b0;
            req_gap_done++;
         end else begin
            req_tdata    <= pending_items[0].data_byte;
            req_tuser    <= pending_items[0].byte_present;
            req_tlast    <= pending_items[0].end_of_message;
            req_tvalid   <= 1'b1;
            rsp_calm     = pending_items[0].calm;
            req_gap_done = 0;
            void'(pending_items.pop_front());
         end
      end
   end

   // Result-side back-pressure: after every accepted digest word the receiver
   // stalls for a freshly drawn number of cycles, and not at all while a calm message runs.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic void queue_item(input logic [7:0] data, input logic present,
                                      input logic final_item, input bit drain,
                                      input bit calm);
      msg_item_type item;
      item.data_byte      = data;
      item.byte_present   = present;
      item.end_of_message = final_item;
      item.gap            = calm ? 0 : $urandom_range(0, 11);
      item.drain          = drain;
      item.calm           = calm;
      pending_items.push_back(item);
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus, end of run and verdict.
   // ---------------------------------------------------------------------
   initial begin
      int  msg_len;
      bit  calm;
      bit  byte_on_final;
      int  edge_lengths [8];

      edge_lengths = '{54, 55, 56, 57, 63, 64, 119, 120};

      // Directed part. The empty message comes first, straight after reset.
      queue_item(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
      // The classic three-byte message.
      queue_item(8'h61, 1'b1, 1'b0, 1'b1, 1'b0);
      queue_item(8'h62, 1'b1, 1'b0, 1'b0, 1'b0);
      queue_item(8'h63, 1'b1, 1'b1, 1'b0, 1'b0);
      // Single-byte messages at both extremes of the byte value.
      queue_item(8'h00, 1'b1, 1'b1, 1'b0, 1'b0);
      queue_item(8'hFF, 1'b1, 1'b1, 1'b0, 1'b0);
      // A transaction without a byte in mid-message is ignored, and the
      // message then ends on a final transaction that adds no byte.
      queue_item(8'hA5, 1'b1, 1'b0, 1'b1, 1'b0);
      queue_item(8'h5A, 1'b1, 1'b0, 1'b0, 1'b0);
      queue_item(8'hFF, 1'b0, 1'b0, 1'b0, 1'b0);
      queue_item(8'h3C, 1'b0, 1'b1, 1'b0, 1'b0);
      // An ignored transaction ahead of an otherwise empty message.
      queue_item(8'hFF, 1'b0, 1'b0, 1'b0, 1'b0);
      queue_item(8'hFF, 1'b0, 1'b1, 1'b0, 1'b0);
      // Walking-one bytes, sent back to back with no stalls.
      for (int i = 0; i < 8; i++) begin
         queue_item(8'(1 << i), 1'b1, (i == 7), 1'b0, 1'b1);
      end

      // Random part: mostly short messages, with lengths around the padding
      // and block boundaries mixed in, some noise transactions, and a share
      // of messages that run with no idling on either side.
      while (pending_items.size() < 400) begin
         msg_len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 12)
                                               : edge_lengths[$urandom_range(0, 7)];
         calm = ($urandom_range(0, 3) == 0);
         byte_on_final = (msg_len > 0) && $urandom_range(0, 1);
         for (int i = 0; i < msg_len; i++) begin
            if ($urandom_range(0, 11) == 0) begin
               queue_item(8'($urandom), 1'b0, 1'b0, 1'b0, calm);
            end
            queue_item(8'($urandom), 1'b1, byte_on_final && (i == msg_len - 1),
                       (i == 0) && ($urandom_range(0, 4) == 0), calm);
         end
         if (!byte_on_final) begin
            queue_item(8'($urandom), 1'b0, 1'b1, (msg_len == 0) && $urandom_range(0, 1),
                       calm);
         end
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Let the stimulus drain, then wait out the longest padding and
      // compression time for any stray digest word.
      while (pending_items.size() != 0 || req_tvalid) begin
         @(posedge clock);
      end
      while (digest_words_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (400) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #4000000;
      $display("FAIL");
      $finish;
   end

endmodule
